### design/mglr_pkg.sv
// shared types, constants and preset tables for the motion gated loop recorder
package mglr_pkg;

    localparam int STORE_DEPTH_DEF = 65536;
    localparam int FRAME_LEN_DEF   = 128;

    localparam int SAMPLE_W   = 16;
    localparam int LEN_W      = 17;
    localparam int SENS_W     = 2;
    localparam int COEFF_W    = 16;
    localparam int HOLD_W     = 14;
    localparam int LEVEL_W    = 24;
    localparam int THRESH_W   = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_ENABLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLEW_COEFF  = 2'd3;

    localparam logic [SENS_W-1:0] SENS_COARSE = 2'd0;
    localparam logic [SENS_W-1:0] SENS_MEDIUM = 2'd1;
    localparam logic [SENS_W-1:0] SENS_FINE   = 2'd2;

    typedef struct packed {
        logic                       run_gate;
        logic                       rewind_gate;
        logic                       erase_gate;
        logic signed [SAMPLE_W-1:0] fader_offset;
        logic                       frame_start;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_sample;
        logic                       write_active;
    } t_out_item;

    typedef struct packed {
        logic                       valid;
        logic                       play;
        logic                       bypass;
        logic signed [SAMPLE_W-1:0] bypass_val;
        logic                       moving;
        logic signed [SAMPLE_W-1:0] rd_data;
    } t_trk_stage;

    function automatic logic [THRESH_W-1:0] move_thresh(input logic [SENS_W-1:0] sel);
        logic [THRESH_W-1:0] t;
        case (sel)
            SENS_COARSE: t = 8'd163;
            SENS_MEDIUM: t = 8'd65;
            default:     t = 8'd16;
        endcase
        return t;
    endfunction

    function automatic logic [HOLD_W-1:0] holdoff_load(input logic [SENS_W-1:0] sel);
        logic [HOLD_W-1:0] h;
        case (sel)
            SENS_COARSE: h = 14'd8192;
            SENS_MEDIUM: h = 14'd4096;
            default:     h = 14'd1024;
        endcase
        return h;
    endfunction

endpackage

### design/mglr_track.sv
// motion detection, holdoff, head control and the loop store with its clearing sweep
module mglr_track #(
    parameter int STORE_DEPTH = mglr_pkg::STORE_DEPTH_DEF,
    parameter int FRAME_LEN   = mglr_pkg::FRAME_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_item_valid,
    input  mglr_pkg::t_in_item            i_item,
    input  logic [mglr_pkg::LEN_W-1:0]    i_loop_length,
    input  logic [mglr_pkg::SENS_W-1:0]   i_sensitivity,
    output logic                          o_clr_busy,
    output mglr_pkg::t_trk_stage          o_trk
);
    localparam int AW = $clog2(STORE_DEPTH);
    localparam int CW = (AW + 1 > mglr_pkg::LEN_W) ? AW + 1 : mglr_pkg::LEN_W;
    localparam int SW = mglr_pkg::SAMPLE_W;
    localparam int HW = mglr_pkg::HOLD_W;

    logic signed [SW-1:0] r_mem [STORE_DEPTH];
    logic signed [SW-1:0] r_rd;

    logic [AW-1:0]        r_head, n_head;
    logic signed [SW-1:0] r_last, n_last;
    logic                 r_moving, n_moving;
    logic [HW-1:0]        r_hold, n_hold;
    logic                 r_rew_hi;
    logic                 r_clr_busy;
    logic [AW-1:0]        r_clr_addr;

    logic                 r_valid, r_play, r_bypass, r_moving_out;
    logic signed [SW-1:0] r_bypass_val;

    logic [CW-1:0]                 len_c;
    logic                          len_zero;
    logic                          go;
    logic [mglr_pkg::SENS_W-1:0]   sel;
    logic signed [SW:0]            delta;
    logic [SW:0]                   mag;
    logic                          moving_mid;
    logic [HW-1:0]                 hold_mid;
    logic [AW-1:0]                 head_cur;
    logic [CW-1:0]                 step;
    logic                          wr;
    logic signed [SW-1:0]          wval;

    always_comb begin
        len_c = (CW'(i_loop_length) > CW'(STORE_DEPTH)) ? CW'(STORE_DEPTH) : CW'(i_loop_length);
        len_zero = (i_loop_length == '0);
        go = i_adv && i_item_valid && !len_zero;
        sel = (i_sensitivity > mglr_pkg::SENS_FINE) ? mglr_pkg::SENS_FINE : i_sensitivity;

        delta = {i_item.fader_offset[SW-1], i_item.fader_offset} - {r_last[SW-1], r_last};
        mag = delta[SW] ? (SW+1)'(-delta) : (SW+1)'(delta);

        moving_mid = r_moving;
        hold_mid = r_hold;
        n_last = r_last;
        if (i_item.frame_start) begin
            if (mag > (SW+1)'(mglr_pkg::move_thresh(sel))) begin
                moving_mid = 1'b1;
                hold_mid = mglr_pkg::holdoff_load(sel);
            end
            n_last = i_item.fader_offset;
        end
        n_moving = moving_mid;
        n_hold = hold_mid;
        if (i_item.frame_start && hold_mid != '0) begin
            if (hold_mid <= HW'(FRAME_LEN)) begin
                n_hold = '0;
                n_moving = 1'b0;
            end else begin
                n_hold = hold_mid - HW'(FRAME_LEN);
            end
        end

        head_cur = (i_item.rewind_gate && !r_rew_hi) ? '0 : r_head;
        wr = i_item.run_gate && (n_moving || i_item.erase_gate);
        wval = n_moving ? i_item.fader_offset : '0;
        step = CW'(head_cur) + CW'(1);
        n_head = head_cur;
        if (i_item.run_gate) begin
            n_head = (step >= len_c) ? '0 : step[AW-1:0];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_last <= '0;
            r_moving <= 1'b0;
            r_hold <= '0;
            r_rew_hi <= 1'b0;
        end else if (go) begin
            r_head <= n_head;
            r_last <= n_last;
            r_moving <= n_moving;
            r_hold <= n_hold;
            r_rew_hi <= i_item.rewind_gate;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(STORE_DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // loop store
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (go && wr) begin
            r_mem[head_cur] <= wval;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_rd <= r_mem[head_cur];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_play <= i_item.run_gate && !len_zero;
            r_bypass <= wr;
            r_bypass_val <= wval;
            r_moving_out <= len_zero ? r_moving : n_moving;
        end
    end

    assign o_clr_busy = r_clr_busy;

    always_comb begin
        o_trk.valid = r_valid;
        o_trk.play = r_play;
        o_trk.bypass = r_bypass;
        o_trk.bypass_val = r_bypass_val;
        o_trk.moving = r_moving_out;
        o_trk.rd_data = r_rd;
    end

endmodule

### design/mglr_slew.sv
// one-pole output slew and the result register
module mglr_slew (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  mglr_pkg::t_trk_stage           i_trk,
    input  logic                           i_slew_enable,
    input  logic [mglr_pkg::COEFF_W-1:0]   i_slew_coeff,
    output logic                           o_valid,
    output mglr_pkg::t_out_item            o_item
);
    localparam int SW = mglr_pkg::SAMPLE_W;
    localparam int LW = mglr_pkg::LEVEL_W;
    localparam int KW = mglr_pkg::COEFF_W;
    localparam int PW = LW + 1 + KW + 1;

    logic signed [LW-1:0] r_level, n_level;
    logic                 r_valid;
    mglr_pkg::t_out_item  r_item;

    logic signed [SW-1:0] raw;
    logic signed [LW-1:0] target;
    logic signed [LW:0]   diff;
    logic signed [KW:0]   coeff_s;
    logic signed [PW-1:0] prod;
    logic signed [LW:0]   lvl_sum;
    logic signed [LW:0]   rounded;
    logic signed [SW-1:0] sample;

    always_comb begin
        raw = i_trk.bypass ? i_trk.bypass_val : i_trk.rd_data;
        target = {raw, 8'b0};
        diff = {target[LW-1], target} - {r_level[LW-1], r_level};
        coeff_s = {1'b0, i_slew_coeff};
        prod = diff * coeff_s;
        lvl_sum = {r_level[LW-1], r_level} + prod[PW-2:KW];
        rounded = {lvl_sum[LW-1], lvl_sum[LW-1:0]} + (LW+1)'(128);

        n_level = r_level;
        sample = '0;
        if (i_trk.play) begin
            if (i_slew_enable) begin
                n_level = lvl_sum[LW-1:0];
                sample = rounded[LW-1:8];
            end else begin
                n_level = target;
                sample = raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_level <= '0;
        end else if (i_adv) begin
            r_valid <= i_trk.valid;
            if (i_trk.valid) begin
                r_level <= n_level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item.out_sample <= sample;
            r_item.write_active <= i_trk.moving;
        end
    end

    assign o_valid = r_valid;
    assign o_item = r_item;

endmodule

### design/motion_gated_loop_recorder.sv
// top level of the motion gated loop recorder
// Takes one control tick per clock cycle when the output side keeps up and no clearing sweep
// runs; each result passes through the input register, loop store access, then slew and
// result register, and the loop store's single registered read per cycle sets that rate.
// After reset the store is swept to zero, one entry a cycle, and no request is taken until
// the sweep has finished; configuration writes are taken throughout.
module motion_gated_loop_recorder #(
    parameter int STORE_DEPTH = mglr_pkg::STORE_DEPTH_DEF,
    parameter int FRAME_LEN   = mglr_pkg::FRAME_LEN_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  mglr_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output mglr_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_wr_en,
    input  logic [mglr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [mglr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    logic [mglr_pkg::LEN_W-1:0]   r_loop_length;
    logic [mglr_pkg::SENS_W-1:0]  r_sensitivity;
    logic                         r_slew_enable;
    logic [mglr_pkg::COEFF_W-1:0] r_slew_coeff;

    logic                 r_a_valid;
    mglr_pkg::t_in_item   r_a_item;

    logic                 adv;
    logic                 clr_busy;
    logic                 accept;
    mglr_pkg::t_trk_stage trk;

    assign adv = !o_out_valid || i_out_ready;
    assign o_in_ready = adv && !clr_busy;
    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_loop_length <= '0;
            r_sensitivity <= '0;
            r_slew_enable <= 1'b0;
            r_slew_coeff <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                mglr_pkg::CFG_LOOP_LENGTH: r_loop_length <= i_cfg_data[mglr_pkg::LEN_W-1:0];
                mglr_pkg::CFG_SENSITIVITY: r_sensitivity <= i_cfg_data[mglr_pkg::SENS_W-1:0];
                mglr_pkg::CFG_SLEW_ENABLE: r_slew_enable <= i_cfg_data[0];
                mglr_pkg::CFG_SLEW_COEFF:  r_slew_coeff <= i_cfg_data[mglr_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_item <= i_in_data;
        end
    end

    mglr_track #(
        .STORE_DEPTH (STORE_DEPTH),
        .FRAME_LEN   (FRAME_LEN)
    ) u_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_item_valid  (r_a_valid),
        .i_item        (r_a_item),
        .i_loop_length (r_loop_length),
        .i_sensitivity (r_sensitivity),
        .o_clr_busy    (clr_busy),
        .o_trk         (trk)
    );

    mglr_slew u_slew (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_trk         (trk),
        .i_slew_enable (r_slew_enable),
        .i_slew_coeff  (r_slew_coeff),
        .o_valid       (o_out_valid),
        .o_item        (o_out_data)
    );

endmodule

### design/mglr_checker.sv
// port-level checks for the motion gated loop recorder, bound to the top level
module mglr_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                o_in_ready,
    input  logic                o_out_valid,
    input  logic                i_out_ready,
    input  mglr_pkg::t_out_item o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // a stalled output freezes the whole pipe
    a_no_take_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("request taken while output stalled");

    // reset empties the pipe and starts the store sweep
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("not idle after reset");

    // a taken request reaches the output through the input, track and result registers when the output keeps up
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready ##1 i_out_ready ##1 i_out_ready |=> o_out_valid)
        else $error("result missing after three cycles");

endmodule

bind motion_gated_loop_recorder mglr_checker u_mglr_checker (.*);
